FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// shared types and constants of the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

   typedef logic [2:0] mode_type;
   typedef logic [7:0] byte_type;

   // command codes
   localparam mode_type MODE_START    = 3'd0;
   localparam mode_type MODE_STOP     = 3'd1;
   localparam mode_type MODE_WRITE    = 3'd2;
   localparam mode_type MODE_READ     = 3'd3;
   localparam mode_type MODE_WAIT_ACK = 3'd4;

   localparam int FRAME_HOLD_TICKS_DEF = 4;
   localparam int BIT_PHASE_TICKS_DEF  = 2;

   localparam byte_type ACK_TIMEOUT_RESET = 8'd250;

endpackage

FILE: sv/i2cmbe_ifs.sv
// ----------------------------------------------------------------------------
// i2cmbe channel interfaces
// tick request, line result and timeout register write channels
// ----------------------------------------------------------------------------
interface i2cmbe_req_if;
   import i2cmbe_pkg::*;
   logic     valid;
   logic     ready;
   logic     command_valid;
   mode_type mode;
   byte_type write_byte;
   logic     send_ack;
   logic     sda_sample;

   modport source (output valid, command_valid, mode, write_byte, send_ack, sda_sample,
                   input ready);
   modport sink (input valid, command_valid, mode, write_byte, send_ack, sda_sample,
                 output ready);
endinterface

interface i2cmbe_rsp_if;
   import i2cmbe_pkg::*;
   logic     valid;
   logic     ready;
   logic     scl_level;
   logic     sda_level;
   logic     busy_res;
   logic     done_res;
   byte_type read_byte;
   logic     ack_failed;

   modport source (output valid, scl_level, sda_level, busy_res, done_res, read_byte,
                   ack_failed, input ready);
   modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_byte,
                 ack_failed, output ready);
endinterface

interface i2cmbe_csr_if;
   import i2cmbe_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: sv/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// i2c master bit engine: start, stop, byte write, byte read, acknowledge wait
// ----------------------------------------------------------------------------
// usage
//   req_ch carries one time-base tick per item: an optional command (taken
//   only while the engine is idle) and the sampled sda level of that tick
//   rsp_ch returns one item per tick: scl/sda drives after the tick, busy,
//   done, the last read byte and the acknowledge timeout flag
//   csr_ch writes the 8-bit acknowledge timeout limit, always ready; write it
//   only while the engine is idle
// latency and throughput
//   one tick item per clock cycle; the result of a tick is valid in the
//   cycle after it is taken, held in a single result register
// reset
//   synchronous, active high: phase idle, both lines released, timeout
//   limit 250, no result pending
// stall
//   while the result register is full and rsp_ch.ready is low, req_ch.ready
//   drops and the engine holds its state; no tick is lost
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_bit_engine #(
   parameter int FRAME_HOLD_TICKS = i2cmbe_pkg::FRAME_HOLD_TICKS_DEF,
   parameter int BIT_PHASE_TICKS  = i2cmbe_pkg::BIT_PHASE_TICKS_DEF
) (
   input logic          clock,
   input logic          reset,
   i2cmbe_req_if.sink   req_ch,
   i2cmbe_rsp_if.source rsp_ch,
   i2cmbe_csr_if.sink   csr_ch
);
   import i2cmbe_pkg::*;

   // phase codes
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_START_A  = 4'd1;
   localparam logic [3:0] PH_START_B  = 4'd2;
   localparam logic [3:0] PH_STOP_A   = 4'd3;
   localparam logic [3:0] PH_STOP_B   = 4'd4;
   localparam logic [3:0] PH_WR_SETUP = 4'd5;
   localparam logic [3:0] PH_WR_HIGH  = 4'd6;
   localparam logic [3:0] PH_WR_LOW   = 4'd7;
   localparam logic [3:0] PH_RD_LOW   = 4'd8;
   localparam logic [3:0] PH_RD_HIGH  = 4'd9;
   localparam logic [3:0] PH_ACK_LOW  = 4'd10;
   localparam logic [3:0] PH_ACK_HIGH = 4'd11;
   localparam logic [3:0] PH_WA_REL   = 4'd12;
   localparam logic [3:0] PH_WA_CLK   = 4'd13;
   localparam logic [3:0] PH_WA_POLL  = 4'd14;

   // phase lengths in the 3-bit tick counter
   localparam logic [2:0] FRAME_LEN = 3'(FRAME_HOLD_TICKS);
   localparam logic [2:0] BIT_LEN   = 3'(BIT_PHASE_TICKS);
   localparam logic [3:0] BYTE_BITS = 4'd8;

   // engine state
   logic [3:0] phase_ff, phase_in;
   logic [2:0] tick_ff, tick_in;
   logic [3:0] bit_ff, bit_in;
   byte_type   shift_ff, shift_in;
   byte_type   poll_ff, poll_in;
   logic       ack_choice_ff, ack_choice_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   byte_type   last_read_ff, last_read_in;
   logic       timeout_ff, timeout_in;
   byte_type   limit_ff;
   logic       done_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_fail_ff;
   byte_type   rsp_read_ff;

   logic       tick_take;
   logic [2:0] tick_next;
   logic       frame_over, bit_over;
   logic [3:0] bit_next;
   logic [8:0] poll_next;

   // a tick goes in whenever the result register is free or being emptied
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign tick_take    = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // phase timer: wrap to zero also ends a phase
   assign tick_next  = tick_ff + 3'd1;
   assign frame_over = (tick_next == 3'd0) || (tick_next >= FRAME_LEN);
   assign bit_over   = (tick_next == 3'd0) || (tick_next >= BIT_LEN);
   assign bit_next   = bit_ff + 4'd1;
   assign poll_next  = {1'b0, poll_ff} + 9'd1;

   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      poll_in       = poll_ff;
      ack_choice_in = ack_choice_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      last_read_in  = last_read_ff;
      timeout_in    = timeout_ff;
      done_in       = 1'b0;

      case (phase_ff)
         PH_START_A: begin
            tick_in = frame_over ? 3'd0 : tick_next;
            if (frame_over) begin
               sda_in   = 1'b0;
               phase_in = PH_START_B;
            end
         end
         PH_START_B: begin
            tick_in = frame_over ? 3'd0 : tick_next;
            if (frame_over) begin
               scl_in   = 1'b0;
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         PH_STOP_A: begin
            tick_in = frame_over ? 3'd0 : tick_next;
            if (frame_over) begin
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               phase_in = PH_STOP_B;
            end
         end
         PH_STOP_B: begin
            tick_in = frame_over ? 3'd0 : tick_next;
            if (frame_over) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         PH_WR_SETUP: begin
            tick_in = bit_over ? 3'd0 : tick_next;
            if (bit_over) begin
               scl_in   = 1'b1;
               phase_in = PH_WR_HIGH;
            end
         end
         PH_WR_HIGH: begin
            tick_in = bit_over ? 3'd0 : tick_next;
            if (bit_over) begin
               scl_in   = 1'b0;
               phase_in = PH_WR_LOW;
            end
         end
         PH_WR_LOW: begin
            tick_in = bit_over ? 3'd0 : tick_next;
            if (bit_over) begin
               bit_in = bit_next;
               if (bit_next >= BYTE_BITS) begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end else begin
                  // next data bit, msb first
                  sda_in   = shift_ff[7];
                  shift_in = {shift_ff[6:0], 1'b0};
                  phase_in = PH_WR_SETUP;
               end
            end
         end
         PH_RD_LOW: begin
            tick_in = bit_over ? 3'd0 : tick_next;
            if (bit_over) begin
               // scl rises and the line is sampled on the same tick
               scl_in   = 1'b1;
               shift_in = {shift_ff[6:0], req_ch.sda_sample};
               phase_in = PH_RD_HIGH;
            end
         end
         PH_RD_HIGH: begin
            // one tick high
            tick_in = 3'd0;
            scl_in  = 1'b0;
            bit_in  = bit_next;
            if (bit_next >= BYTE_BITS) begin
               last_read_in = shift_ff;
               sda_in       = !ack_choice_ff;
               phase_in     = PH_ACK_LOW;
            end else begin
               phase_in = PH_RD_LOW;
            end
         end
         PH_ACK_LOW: begin
            tick_in = bit_over ? 3'd0 : tick_next;
            if (bit_over) begin
               scl_in   = 1'b1;
               phase_in = PH_ACK_HIGH;
            end
         end
         PH_ACK_HIGH: begin
            tick_in = bit_over ? 3'd0 : tick_next;
            if (bit_over) begin
               scl_in   = 1'b0;
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         PH_WA_REL: begin
            tick_in  = 3'd0;
            scl_in   = 1'b1;
            phase_in = PH_WA_CLK;
         end
         PH_WA_CLK: begin
            tick_in  = 3'd0;
            phase_in = PH_WA_POLL;
         end
         PH_WA_POLL: begin
            if (!req_ch.sda_sample) begin
               // slave acknowledged
               scl_in     = 1'b0;
               timeout_in = 1'b0;
               tick_in    = 3'd0;
               phase_in   = PH_IDLE;
               done_in    = 1'b1;
            end else if (poll_next > {1'b0, limit_ff}) begin
               // timed out: flag it and release the bus with a stop
               timeout_in = 1'b1;
               scl_in     = 1'b0;
               sda_in     = 1'b0;
               tick_in    = 3'd0;
               phase_in   = PH_STOP_A;
            end else begin
               poll_in = poll_next[7:0];
            end
         end
         default: begin
            // idle, and any unused phase code
            phase_in = PH_IDLE;
            tick_in  = 3'd0;
            if (req_ch.command_valid) begin
               case (req_ch.mode)
                  MODE_START: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                     phase_in = PH_START_A;
                  end
                  MODE_STOP: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     phase_in = PH_STOP_A;
                  end
                  MODE_WRITE: begin
                     scl_in   = 1'b0;
                     bit_in   = 4'd0;
                     sda_in   = req_ch.write_byte[7];
                     shift_in = {req_ch.write_byte[6:0], 1'b0};
                     phase_in = PH_WR_SETUP;
                  end
                  MODE_READ: begin
                     scl_in        = 1'b0;
                     sda_in        = 1'b1;
                     bit_in        = 4'd0;
                     shift_in      = '0;
                     ack_choice_in = req_ch.send_ack;
                     phase_in      = PH_RD_LOW;
                  end
                  MODE_WAIT_ACK: begin
                     sda_in     = 1'b1;
                     poll_in    = '0;
                     timeout_in = 1'b0;
                     phase_in   = PH_WA_REL;
                  end
                  default: begin
                     // undefined command codes are ignored
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   // engine state advances once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         bit_ff        <= '0;
         shift_ff      <= '0;
         poll_ff       <= '0;
         ack_choice_ff <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         last_read_ff  <= '0;
         timeout_ff    <= 1'b0;
      end else if (tick_take) begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         poll_ff       <= poll_in;
         ack_choice_ff <= ack_choice_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         last_read_ff  <= last_read_in;
         timeout_ff    <= timeout_in;
      end
   end

   // timeout limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         limit_ff <= csr_ch.data;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (tick_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_take) begin
         rsp_scl_ff  <= scl_in;
         rsp_sda_ff  <= sda_in;
         rsp_busy_ff <= (phase_in != PH_IDLE);
         rsp_done_ff <= done_in;
         rsp_read_ff <= last_read_in;
         rsp_fail_ff <= timeout_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.scl_level  = rsp_scl_ff;
   assign rsp_ch.sda_level  = rsp_sda_ff;
   assign rsp_ch.busy_res   = rsp_busy_ff;
   assign rsp_ch.done_res   = rsp_done_ff;
   assign rsp_ch.read_byte  = rsp_read_ff;
   assign rsp_ch.ack_failed = rsp_fail_ff;

   // a finished sequence always leaves the engine idle
   `ASSERT_IMPLY(a_done_not_busy, clock, reset, rsp_valid_ff && rsp_done_ff, !rsp_busy_ff)
   // scl is released for the whole acknowledge poll
   `ASSERT_IMPLY(a_poll_scl_high, clock, reset, phase_ff == PH_WA_POLL, scl_ff)
   // both lines are released while a start condition is set up
   `ASSERT_IMPLY(a_start_released, clock, reset, phase_ff == PH_START_A, scl_ff && sda_ff)
   // a timeout is only ever flagged together with the forced stop
   `ASSERT_IMPLY(a_timeout_stop, clock, reset, $rose(timeout_ff), phase_ff == PH_STOP_A)
   // a taken tick always yields a result
   `ASSERT_NEXT(a_take_result, clock, reset, tick_take, rsp_valid_ff)

endmodule

FILE: verif/i2c_master_bit_engine_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// drives tick items into the i2c master bit engine and checks every line
// result item against a tick-exact model of the start, stop, write, read and
// acknowledge wait sequences, across several acknowledge timeout limits
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cmbe_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_TICKS  = 180;

   localparam int FRAME_TICKS = FRAME_HOLD_TICKS_DEF;
   localparam int BIT_TICKS   = BIT_PHASE_TICKS_DEF;

   // how sda is sampled outside the acknowledge poll
   localparam int SDA_RANDOM = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_LOW    = 2;

   // bus sequence phases of the engine
   typedef enum logic [3:0] {
      BP_IDLE,
      BP_START_HOLD,
      BP_START_LOW,
      BP_STOP_LOW,
      BP_STOP_HIGH,
      BP_WR_SETUP,
      BP_WR_HIGH,
      BP_WR_LOW,
      BP_RD_LOW,
      BP_RD_HIGH,
      BP_ACK_LOW,
      BP_ACK_HIGH,
      BP_WA_RELEASE,
      BP_WA_CLOCK,
      BP_WA_POLL
   } bus_phase_type;

   // one tick item on the request channel
   typedef struct packed {
      logic     command_valid;
      mode_type mode;
      byte_type write_byte;
      logic     send_ack;
      logic     sda_sample;
   } tick_item_type;

   // one item on the result channel
   typedef struct packed {
      logic     scl_level;
      logic     sda_level;
      logic     busy_res;
      logic     done_res;
      byte_type read_byte;
      logic     ack_failed;
   } line_result_type;

   // line model plus the queue of line results still owed by the engine
   class line_scoreboard;
      byte_type        timeout_limit;
      bus_phase_type   phase;
      logic [2:0]      tick_count;
      logic [3:0]      bit_count;
      byte_type        shift_byte;
      byte_type        poll_count;
      logic            ack_choice;
      logic            clock_drive;
      logic            data_drive;
      byte_type        last_read;
      logic            timeout_flag;
      line_result_type expected_lines[$];
      int unsigned     failures;
      int unsigned     ticks_taken;

      function new();
         timeout_limit = ACK_TIMEOUT_RESET;
         phase         = BP_IDLE;
         tick_count    = '0;
         bit_count     = '0;
         shift_byte    = '0;
         poll_count    = '0;
         ack_choice    = 1'b0;
         clock_drive   = 1'b1;
         data_drive    = 1'b1;
         last_read     = '0;
         timeout_flag  = 1'b0;
         failures      = 0;
         ticks_taken   = 0;
      endfunction

      function void set_limit(byte_type value);
         timeout_limit = value;
      endfunction

      function bit is_busy();
         return phase != BP_IDLE;
      endfunction

      function bit in_poll();
         return phase == BP_WA_POLL;
      endfunction

      function int pending();
         return expected_lines.size();
      endfunction

      // counts a tick of the phase, true once it has lasted dur ticks
      function bit hold_elapsed(int dur);
         logic [2:0] nxt;
         nxt = tick_count + 3'd1;
         if (nxt >= dur || nxt == 3'd0) begin
            tick_count = '0;
            return 1'b1;
         end
         tick_count = nxt;
         return 1'b0;
      endfunction

      function void enter_phase(bus_phase_type ph);
         phase      = ph;
         tick_count = '0;
      endfunction

      function void next_write_bit();
         data_drive = shift_byte[7];
         shift_byte = {shift_byte[6:0], 1'b0};
         enter_phase(BP_WR_SETUP);
      endfunction

      function void take_tick(tick_item_type item);
         logic            done;
         int unsigned     next_poll;
         line_result_type line;
         done = 1'b0;
         ticks_taken++;
         case (phase)
            BP_START_HOLD: if (hold_elapsed(FRAME_TICKS)) begin
               data_drive = 1'b0;
               enter_phase(BP_START_LOW);
            end
            BP_START_LOW: if (hold_elapsed(FRAME_TICKS)) begin
               clock_drive = 1'b0;
               enter_phase(BP_IDLE);
               done = 1'b1;
            end
            BP_STOP_LOW: if (hold_elapsed(FRAME_TICKS)) begin
               clock_drive = 1'b1;
               data_drive  = 1'b1;
               enter_phase(BP_STOP_HIGH);
            end
            BP_STOP_HIGH: if (hold_elapsed(FRAME_TICKS)) begin
               enter_phase(BP_IDLE);
               done = 1'b1;
            end
            BP_WR_SETUP: if (hold_elapsed(BIT_TICKS)) begin
               clock_drive = 1'b1;
               enter_phase(BP_WR_HIGH);
            end
            BP_WR_HIGH: if (hold_elapsed(BIT_TICKS)) begin
               clock_drive = 1'b0;
               enter_phase(BP_WR_LOW);
            end
            BP_WR_LOW: if (hold_elapsed(BIT_TICKS)) begin
               bit_count = bit_count + 4'd1;
               if (bit_count >= 4'd8) begin
                  enter_phase(BP_IDLE);
                  done = 1'b1;
               end else begin
                  next_write_bit();
               end
            end
            BP_RD_LOW: if (hold_elapsed(BIT_TICKS)) begin
               clock_drive = 1'b1;
               shift_byte  = {shift_byte[6:0], item.sda_sample};
               enter_phase(BP_RD_HIGH);
            end
            BP_RD_HIGH: if (hold_elapsed(1)) begin
               clock_drive = 1'b0;
               bit_count   = bit_count + 4'd1;
               if (bit_count >= 4'd8) begin
                  last_read  = shift_byte;
                  data_drive = !ack_choice;
                  enter_phase(BP_ACK_LOW);
               end else begin
                  enter_phase(BP_RD_LOW);
               end
            end
            BP_ACK_LOW: if (hold_elapsed(BIT_TICKS)) begin
               clock_drive = 1'b1;
               enter_phase(BP_ACK_HIGH);
            end
            BP_ACK_HIGH: if (hold_elapsed(BIT_TICKS)) begin
               clock_drive = 1'b0;
               enter_phase(BP_IDLE);
               done = 1'b1;
            end
            BP_WA_RELEASE: if (hold_elapsed(1)) begin
               clock_drive = 1'b1;
               enter_phase(BP_WA_CLOCK);
            end
            BP_WA_CLOCK: if (hold_elapsed(1)) begin
               enter_phase(BP_WA_POLL);
            end
            BP_WA_POLL: begin
               if (!item.sda_sample) begin
                  clock_drive  = 1'b0;
                  timeout_flag = 1'b0;
                  enter_phase(BP_IDLE);
                  done = 1'b1;
               end else begin
                  // compared before the 8-bit count could wrap
                  next_poll = poll_count + 1;
                  if (next_poll > timeout_limit) begin
                     timeout_flag = 1'b1;
                     clock_drive  = 1'b0;
                     data_drive   = 1'b0;
                     enter_phase(BP_STOP_LOW);
                  end else begin
                     poll_count = next_poll[7:0];
                  end
               end
            end
            default: begin
               enter_phase(BP_IDLE);
               if (item.command_valid && item.mode <= MODE_WAIT_ACK) begin
                  case (item.mode)
                     MODE_START: begin
                        clock_drive = 1'b1;
                        data_drive  = 1'b1;
                        enter_phase(BP_START_HOLD);
                     end
                     MODE_STOP: begin
                        clock_drive = 1'b0;
                        data_drive  = 1'b0;
                        enter_phase(BP_STOP_LOW);
                     end
                     MODE_WRITE: begin
                        clock_drive = 1'b0;
                        bit_count   = '0;
                        shift_byte  = item.write_byte;
                        next_write_bit();
                     end
                     MODE_READ: begin
                        clock_drive = 1'b0;
                        data_drive  = 1'b1;
                        bit_count   = '0;
                        shift_byte  = '0;
                        ack_choice  = item.send_ack;
                        enter_phase(BP_RD_LOW);
                     end
                     default: begin
                        data_drive   = 1'b1;
                        poll_count   = '0;
                        timeout_flag = 1'b0;
                        enter_phase(BP_WA_RELEASE);
                     end
                  endcase
               end
            end
         endcase
         line.scl_level  = clock_drive;
         line.sda_level  = data_drive;
         line.busy_res   = (phase != BP_IDLE);
         line.done_res   = done;
         line.read_byte  = last_read;
         line.ack_failed = timeout_flag;
         expected_lines.push_back(line);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_lines(line_result_type got);
         line_result_type want;
         if (expected_lines.size() == 0) begin
            failures++;
            $display("%0t: result item expected none actual %h", $time, got);
            return;
         end
         want = expected_lines.pop_front();
         compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
         compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
         compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
         compare_field("read_byte", want.read_byte, got.read_byte);
         compare_field("ack_failed", 8'(want.ack_failed), 8'(got.ack_failed));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2cmbe_req_if req_ch ();
   i2cmbe_rsp_if rsp_ch ();
   i2cmbe_csr_if csr_ch ();

   line_scoreboard board = new();

   int          burst_left  = 0;
   int          ready_mode  = 0;
   int          ready_span  = 0;
   int unsigned cycle_count = 0;

   i2c_master_bit_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // receiver back-pressure: spans of always ready, light, periodic and heavy stalls
   always @(posedge clock) begin
      if (ready_span == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_span = $urandom_range(20, 200);
      end else begin
         ready_span--;
      end
      case (ready_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_ch.ready <= (ready_span % 3 != 0);
         default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // every accepted result item is checked against the oldest expectation
   always @(posedge clock) begin : result_monitor
      line_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.scl_level  = rsp_ch.scl_level;
         got.sda_level  = rsp_ch.sda_level;
         got.busy_res   = rsp_ch.busy_res;
         got.done_res   = rsp_ch.done_res;
         got.read_byte  = rsp_ch.read_byte;
         got.ack_failed = rsp_ch.ack_failed;
         board.check_lines(got);
      end
   end

   // tick with random content and no command
   function automatic tick_item_type idle_tick();
      tick_item_type item;
      item.command_valid = 1'b0;
      item.mode          = mode_type'($urandom_range(0, 7));
      item.write_byte    = byte_type'($urandom_range(0, 255));
      item.send_ack      = 1'($urandom_range(0, 1));
      item.sda_sample    = 1'($urandom_range(0, 1));
      return item;
   endfunction

   // offers one tick item, in bursts with random gaps between them
   task automatic send_tick(input tick_item_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 5);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
      end
      req_ch.valid         <= 1'b1;
      req_ch.command_valid <= item.command_valid;
      req_ch.mode          <= item.mode;
      req_ch.write_byte    <= item.write_byte;
      req_ch.send_ack      <= item.send_ack;
      req_ch.sda_sample    <= item.sda_sample;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.take_tick(item);
      burst_left--;
   endtask

   // writes the timeout limit once the engine is idle and all results are in
   task automatic write_limit(input byte_type value);
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      board.set_limit(value);
      csr_ch.valid <= 1'b0;
   endtask

   // issues a command and keeps ticking until the sequence is over;
   // polls_high is the number of high sda polls before the slave pulls low
   task automatic run_command(input mode_type mode, input byte_type data, input logic ack,
                              input int sda_kind, input int polls_high, input bit noisy);
      tick_item_type item;
      int            highs;
      item               = idle_tick();
      item.command_valid = 1'b1;
      item.mode          = mode;
      item.write_byte    = data;
      item.send_ack      = ack;
      send_tick(item);
      highs = 0;
      while (board.is_busy()) begin
         item = idle_tick();
         // commands while busy must be ignored
         if (noisy && $urandom_range(0, 3) == 0)
            item.command_valid = 1'b1;
         if (board.in_poll()) begin
            item.sda_sample = (highs < polls_high);
            if (item.sda_sample)
               highs++;
         end else if (sda_kind == SDA_HIGH) begin
            item.sda_sample = 1'b1;
         end else if (sda_kind == SDA_LOW) begin
            item.sda_sample = 1'b0;
         end
         send_tick(item);
      end
   endtask

   task automatic random_command();
      int            pick;
      int            sel;
      int            sda_kind;
      int            polls;
      mode_type      mode;
      tick_item_type item;
      pick = $urandom_range(0, 99);
      if (pick < 15)       mode = MODE_START;
      else if (pick < 30)  mode = MODE_STOP;
      else if (pick < 50)  mode = MODE_WRITE;
      else if (pick < 72)  mode = MODE_READ;
      else if (pick < 94)  mode = MODE_WAIT_ACK;
      else                 mode = mode_type'($urandom_range(5, 7));
      sel = $urandom_range(0, 5);
      if (sel == 4)        sda_kind = SDA_HIGH;
      else if (sel == 5)   sda_kind = SDA_LOW;
      else                 sda_kind = SDA_RANDOM;
      // long limits make the timeout and the just-passing wait costly, so rarer
      sel = $urandom_range(0, (board.timeout_limit > 20) ? 11 : 3);
      if (sel == 2)        polls = int'(board.timeout_limit);
      else if (sel == 3)   polls = int'(board.timeout_limit) + 1;
      else                 polls = $urandom_range(0, 4);
      run_command(mode, byte_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  sda_kind, polls, $urandom_range(0, 2) == 0);
      // a few idle ticks, some carrying an undefined command
      repeat ($urandom_range(0, 2)) begin
         item = idle_tick();
         if ($urandom_range(0, 3) == 0) begin
            item.command_valid = 1'b1;
            item.mode          = mode_type'($urandom_range(5, 7));
         end
         send_tick(item);
      end
   endtask

   initial begin : stimulus
      byte_type    settings [5];
      int unsigned target;
      req_ch.valid         <= 1'b0;
      req_ch.command_valid <= 1'b0;
      req_ch.mode          <= MODE_START;
      req_ch.write_byte    <= '0;
      req_ch.send_ack      <= 1'b0;
      req_ch.sda_sample    <= 1'b1;
      csr_ch.valid         <= 1'b0;
      csr_ch.data          <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every command, byte extremes, ack and nack, reset limit
      run_command(MODE_START, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0);
      run_command(MODE_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 0, 1'b1);
      run_command(MODE_WRITE, 8'h00, 1'b1, SDA_RANDOM, 0, 1'b1);
      run_command(MODE_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 0, 1'b0);
      run_command(MODE_READ, 8'h00, 1'b1, SDA_HIGH, 0, 1'b1);
      run_command(MODE_READ, 8'hFF, 1'b0, SDA_LOW, 0, 1'b0);
      run_command(MODE_READ, 8'h5A, 1'b1, SDA_RANDOM, 0, 1'b0);
      run_command(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b1);
      // undefined modes leave the engine idle
      run_command(3'd5, 8'hFF, 1'b1, SDA_RANDOM, 0, 1'b0);
      run_command(3'd6, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0);
      run_command(3'd7, 8'hFF, 1'b1, SDA_RANDOM, 0, 1'b0);
      // acknowledge at once, after a few polls, right at the limit, past it
      run_command(MODE_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b1);
      run_command(MODE_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 3, 1'b0);
      run_command(MODE_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, int'(ACK_TIMEOUT_RESET), 1'b0);
      run_command(MODE_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, int'(ACK_TIMEOUT_RESET) + 1,
                  1'b1);
      // zero limit: one high poll fails
      write_limit(8'd0);
      run_command(MODE_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 1, 1'b0);
      run_command(MODE_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0);
      // top limit: the poll count must not wrap, fails after 256 high polls
      write_limit(8'd255);
      run_command(MODE_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 256, 1'b0);

      // random command streams under several limits
      settings[0] = byte_type'($urandom_range(2, 20));
      settings[1] = 8'd0;
      settings[2] = 8'd255;
      settings[3] = 8'd1;
      settings[4] = byte_type'($urandom_range(0, 255));
      foreach (settings[i]) begin
         write_limit(settings[i]);
         target = board.ticks_taken + PHASE_TICKS;
         while (board.ticks_taken < target) random_command();
      end

      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
